// File: design/bscu_pkg.sv
// Shared types, constants and arithmetic helpers for the barometric compensation unit.
// No dependencies; every design file but bscu_udiv imports this package.
package bscu_pkg;

    localparam int unsigned DataW  = 32;
    localparam int unsigned CoefW  = 48;
    localparam int unsigned IndexW = 3;

    typedef enum logic [IndexW-1:0] {
        REG_COEF_A = 3'd0,
        REG_COEF_B = 3'd1,
        REG_COEF_C = 3'd2,
        REG_COEF_D = 3'd3,
        REG_OSS    = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] temperature_decicelsius;
        logic signed [31:0] pressure_pascal;
        logic               divide_error;
    } out_beat_t;

    // calibration words, already extended to the datapath width
    typedef struct packed {
        logic signed [31:0] ac1;
        logic signed [31:0] ac2;
        logic signed [31:0] ac3;
        logic signed [31:0] ac4;
        logic signed [31:0] ac5;
        logic signed [31:0] ac6;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] mc;
        logic signed [31:0] md;
        logic        [1:0]  oss;
    } coef_t;

    typedef struct packed {
        logic signed [31:0] x1;
        logic [18:0]        up;
        logic               neg;
        logic               err;
    } front_side_t;

    typedef struct packed {
        logic signed [31:0] t;
        logic               hi;
        logic               err;
    } tail_side_t;

    localparam int unsigned FrontSideW = $bits(front_side_t);
    localparam int unsigned TailSideW  = $bits(tail_side_t);

    // signed divide by four, truncating toward zero
    function automatic logic signed [31:0] div4(input logic signed [31:0] v);
        logic signed [31:0] adj;
        adj = v + (v[31] ? 32'sd3 : 32'sd0);
        return adj >>> 2;
    endfunction

endpackage

// File: design/barometric_sensor_compensation_unit.sv
// Barometric sensor compensation unit, top level.
// Depends on bscu_pkg, bscu_front, bscu_udiv, bscu_poly and bscu_tail.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one beat per sample pair
//   (raw temperature UT and raw pressure UP). Output channel
//   out_valid/out_stall/out_data returns one beat per input beat, in order:
//   temperature in 0.1 degC, pressure in Pa and a divide error flag, which
//   zeroes both results.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the four
//   calibration registers and the oversampling setting; cfg_ready is always
//   high. Write only while the pipeline is empty.
//   Stages: one front stage, two 32-stage dividers (one quotient bit per
//   stage), seven coefficient stages and three tail stages.
//   Throughput is one beat per cycle while the output is not stalled.
//   When out_stall is high with a beat waiting, the whole pipeline holds and
//   in_stall rises; nothing is dropped.
//   Reset empties the pipeline, clears the calibration registers and sets
//   oversampling to 3.
module barometric_sensor_compensation_unit
    import bscu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_beat_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_beat_t         out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IndexW-1:0] cfg_index,
    input  logic [CoefW-1:0]  cfg_data
);

    logic [CoefW-1:0] coef_a_reg, coef_b_reg, coef_c_reg;
    logic [31:0]      coef_d_reg;
    logic [1:0]       oss_reg;
    coef_t            coef;
    logic             adv;

    logic        f_valid;
    logic [31:0] f_num, f_den;
    front_side_t f_side;
    logic        d1_valid;
    logic [31:0] d1_q;
    logic [FrontSideW-1:0] d1_side;
    logic        p_valid;
    logic [31:0] p_num, p_den;
    tail_side_t  p_side;
    logic        d2_valid;
    logic [31:0] d2_q;
    logic [TailSideW-1:0] d2_side;

    assign cfg_ready = 1'b1;
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            coef_c_reg <= '0;
            coef_d_reg <= '0;
            oss_reg    <= 2'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_COEF_A: coef_a_reg <= cfg_data;
                REG_COEF_B: coef_b_reg <= cfg_data;
                REG_COEF_C: coef_c_reg <= cfg_data;
                REG_COEF_D: coef_d_reg <= cfg_data[31:0];
                REG_OSS:    oss_reg    <= cfg_data[1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        coef.ac1 = 32'($signed(coef_a_reg[47:32]));
        coef.ac2 = 32'($signed(coef_a_reg[31:16]));
        coef.ac3 = 32'($signed(coef_a_reg[15:0]));
        coef.ac4 = $signed({16'd0, coef_b_reg[47:32]});
        coef.ac5 = $signed({16'd0, coef_b_reg[31:16]});
        coef.ac6 = $signed({16'd0, coef_b_reg[15:0]});
        coef.b1  = 32'($signed(coef_c_reg[47:32]));
        coef.b2  = 32'($signed(coef_c_reg[31:16]));
        coef.mc  = 32'($signed(coef_d_reg[31:16]));
        coef.md  = 32'($signed(coef_d_reg[15:0]));
        coef.oss = oss_reg;
    end

    bscu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .coef      (coef),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .div_valid (f_valid),
        .div_num   (f_num),
        .div_den   (f_den),
        .div_side  (f_side)
    );

    bscu_udiv #(
        .Width (DataW),
        .SideW (FrontSideW)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (f_valid),
        .dividend  (f_num),
        .divisor   (f_den),
        .side_in   (f_side),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .side_out  (d1_side)
    );

    bscu_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .coef      (coef),
        .in_valid  (d1_valid),
        .quotient  (d1_q),
        .side      (front_side_t'(d1_side)),
        .div_valid (p_valid),
        .div_num   (p_num),
        .div_den   (p_den),
        .div_side  (p_side)
    );

    bscu_udiv #(
        .Width (DataW),
        .SideW (TailSideW)
    ) u_pdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (p_valid),
        .dividend  (p_num),
        .divisor   (p_den),
        .side_in   (p_side),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .side_out  (d2_side)
    );

    bscu_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d2_valid),
        .quotient  (d2_q),
        .side      (tail_side_t'(d2_side)),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: design/bscu_udiv.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with a sideband.
// Depends on nothing; instantiated twice by the top level.
module bscu_udiv #(
    parameter int unsigned Width = 32,
    parameter int unsigned SideW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [Width-1:0] dividend,
    input  logic [Width-1:0] divisor,
    input  logic [SideW-1:0] side_in,
    output logic             out_valid,
    output logic [Width-1:0] quotient,
    output logic [SideW-1:0] side_out
);

    logic             v_reg [Width];
    logic [Width-1:0] n_reg [Width];
    logic [Width-1:0] r_reg [Width];
    logic [Width-1:0] d_reg [Width];
    logic [SideW-1:0] s_reg [Width];

    for (genvar s = 0; s < Width; s++) begin : g_stage
        logic             v_prev;
        logic [Width-1:0] n_prev;
        logic [Width-1:0] r_prev;
        logic [Width-1:0] d_prev;
        logic [SideW-1:0] s_prev;
        logic [Width:0]   trial;
        logic             ge;
        logic [Width-1:0] r_next;
        logic [Width-1:0] n_next;

        if (s == 0) begin : g_first
            assign v_prev = in_valid;
            assign n_prev = dividend;
            assign r_prev = '0;
            assign d_prev = divisor;
            assign s_prev = side_in;
        end else begin : g_rest
            assign v_prev = v_reg[s-1];
            assign n_prev = n_reg[s-1];
            assign r_prev = r_reg[s-1];
            assign d_prev = d_reg[s-1];
            assign s_prev = s_reg[s-1];
        end

        always_comb
        begin
            trial  = {r_prev, n_prev[Width-1]};
            ge     = (trial >= {1'b0, d_prev});
            r_next = ge ? Width'(trial - {1'b0, d_prev}) : trial[Width-1:0];
            n_next = {n_prev[Width-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                n_reg[s] <= n_next;
                r_reg[s] <= r_next;
                d_reg[s] <= d_prev;
                s_reg[s] <= s_prev;
            end
        end
    end

    assign out_valid = v_reg[Width-1];
    assign quotient  = n_reg[Width-1];
    assign side_out  = s_reg[Width-1];

endmodule

// File: design/bscu_front.sv
// Temperature front end: scales UT, forms temperature divide magnitudes and sign.
// Depends on bscu_pkg.
module bscu_front
    import bscu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  coef_t       coef,
    input  logic        in_valid,
    input  in_beat_t    in_data,
    output logic        div_valid,
    output logic [31:0] div_num,
    output logic [31:0] div_den,
    output front_side_t div_side
);

    logic               v_reg;
    logic signed [31:0] prod_reg;
    logic [18:0]        up_reg;
    logic signed [31:0] diff;
    logic signed [31:0] x1;
    logic signed [31:0] den;
    logic signed [31:0] num;

    assign diff = $signed({16'd0, in_data.raw_temperature}) - coef.ac6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= diff * coef.ac5;
            up_reg   <= in_data.raw_pressure;
        end
    end

    always_comb
    begin
        x1            = prod_reg >>> 15;
        den           = x1 + coef.md;
        num           = coef.mc <<< 11;
        div_valid     = v_reg;
        div_num       = num[31] ? 32'(-num) : num;
        div_den       = den[31] ? 32'(-den) : den;
        div_side.x1   = x1;
        div_side.up   = up_reg;
        div_side.neg  = num[31] ^ den[31];
        div_side.err  = (den == 32'sd0);
    end

endmodule

// File: design/bscu_poly.sv
// Pressure coefficient stages: B5, temperature, B6 polynomials, B3, B4, B7.
// Depends on bscu_pkg; feeds the pressure divider.
module bscu_poly
    import bscu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  coef_t       coef,
    input  logic        in_valid,
    input  logic [31:0] quotient,
    input  front_side_t side,
    output logic        div_valid,
    output logic [31:0] div_num,
    output logic [31:0] div_den,
    output tail_side_t  div_side
);

    logic               v_reg [7];
    logic signed [31:0] t_reg [7];
    logic [18:0]        up_reg [7];
    logic               err_reg [7];

    logic signed [31:0] b6_reg;
    logic signed [31:0] sqm_reg, mac2_reg, mac3_reg;
    logic signed [31:0] sq_reg, x2a_reg, x1c_reg;
    logic signed [31:0] mb2_reg, mb1_reg, x2a4_reg, x1c4_reg;
    logic signed [31:0] b3s_reg, x3s_reg;
    logic signed [31:0] b3_reg, x3p_reg;
    logic [31:0]        b4m_reg, b7_reg;

    logic signed [31:0] qs, b5, x3a, b3pre;
    logic [31:0]        b4;

    always_comb
    begin
        qs    = side.neg ? -$signed(quotient) : $signed(quotient);
        b5    = side.x1 + qs;
        x3a   = (mb2_reg >>> 11) + x2a4_reg;
        b3pre = ((coef.ac1 <<< 2) + x3a) <<< coef.oss;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 7; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 7; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0]   <= (b5 + 32'sd8) >>> 4;
            up_reg[0]  <= side.up;
            err_reg[0] <= side.err;
            for (int i = 1; i < 7; i++)
            begin
                t_reg[i]   <= t_reg[i-1];
                up_reg[i]  <= up_reg[i-1];
                err_reg[i] <= err_reg[i-1];
            end
            b6_reg   <= b5 - 32'sd4000;
            sqm_reg  <= b6_reg * b6_reg;
            mac2_reg <= coef.ac2 * b6_reg;
            mac3_reg <= coef.ac3 * b6_reg;
            sq_reg   <= sqm_reg >>> 12;
            x2a_reg  <= mac2_reg >>> 11;
            x1c_reg  <= mac3_reg >>> 13;
            mb2_reg  <= coef.b2 * sq_reg;
            mb1_reg  <= coef.b1 * sq_reg;
            x2a4_reg <= x2a_reg;
            x1c4_reg <= x1c_reg;
            b3s_reg  <= b3pre + 32'sd2;
            x3s_reg  <= x1c4_reg + (mb1_reg >>> 16) + 32'sd2;
            b3_reg   <= div4(b3s_reg);
            x3p_reg  <= div4(x3s_reg) + 32'sd32768;
            b4m_reg  <= $unsigned(coef.ac4) * $unsigned(x3p_reg);
            b7_reg   <= ({13'd0, up_reg[5]} - $unsigned(b3_reg))
                        * (32'd50000 >> coef.oss);
        end
    end

    always_comb
    begin
        b4            = b4m_reg >> 15;
        div_valid     = v_reg[6];
        div_den       = b4;
        div_num       = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
        div_side.t    = t_reg[6];
        div_side.hi   = b7_reg[31];
        div_side.err  = err_reg[6] | (b4 == 32'd0);
    end

endmodule

// File: design/bscu_tail.sv
// Final pressure correction polynomial and the output register.
// Depends on bscu_pkg.
module bscu_tail
    import bscu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  logic [31:0] quotient,
    input  tail_side_t  side,
    output logic        out_valid,
    output out_beat_t   out_data
);

    logic               v1_reg, v2_reg, vo_reg;
    logic signed [31:0] t1_reg, t2_reg;
    logic               e1_reg, e2_reg;
    logic signed [31:0] p1_reg, p2_reg;
    logic signed [31:0] sq_reg, m7_reg, x1m_reg, x2_reg;
    out_beat_t          out_reg;

    logic signed [31:0] p, a, x1, pf;

    always_comb
    begin
        p  = side.hi ? $signed({quotient[30:0], 1'b0}) : $signed(quotient);
        a  = p >>> 8;
        x1 = x1m_reg >>> 16;
        pf = p2_reg + ((x1 + x2_reg + 32'sd3791) >>> 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            vo_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg  <= p;
            t1_reg  <= side.t;
            e1_reg  <= side.err;
            sq_reg  <= a * a;
            m7_reg  <= -32'sd7357 * p;
            p2_reg  <= p1_reg;
            t2_reg  <= t1_reg;
            e2_reg  <= e1_reg;
            x1m_reg <= sq_reg * 32'sd3038;
            x2_reg  <= m7_reg >>> 16;
            out_reg.divide_error            <= e2_reg;
            out_reg.temperature_decicelsius <= e2_reg ? 32'sd0 : t2_reg;
            out_reg.pressure_pascal         <= e2_reg ? 32'sd0 : pf;
        end
    end

    assign out_valid = vo_reg;
    assign out_data  = out_reg;

endmodule

// File: verif/barometric_sensor_compensation_unit_test.sv
// Self-checking testbench for the barometric compensation unit: directed table, then random
// sample pairs across several calibration sets, checked against an in-bench predictor.
// Depends on bscu_pkg and barometric_sensor_compensation_unit.
module barometric_sensor_compensation_unit_test
    import bscu_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 75;

    typedef struct {
        in_beat_t  sample;
        bit        known;
        out_beat_t result;
    } vector_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    in_beat_t          in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    out_beat_t         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IndexW-1:0] cfg_index = '0;
    logic [CoefW-1:0]  cfg_data = '0;

    logic [47:0] cal_a, cal_b, cal_c;
    logic [31:0] cal_d;
    logic [1:0]  cal_oss;

    out_beat_t pending_results[$];
    vector_t   vectors[$];
    int        errors = 0;
    int        beats_out = 0;
    int        error_beats = 0;
    int        rx_wait = 0;
    bit        hold_off = 1'b0;

    barometric_sensor_compensation_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic signed [31:0] sdiv(logic signed [31:0] n, logic signed [31:0] d);
        logic [31:0] un, ud, uq;
        un = n[31] ? -n : n;
        ud = d[31] ? -d : d;
        uq = un / ud;
        return (n[31] ^ d[31]) ? -uq : uq;
    endfunction

    function automatic out_beat_t compensate(in_beat_t s);
        logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic signed [31:0] x1, x2, x3, b3, b5, b6, sq, t, p, den;
        logic [31:0] b4, b7, q;
        out_beat_t r;
        ac1 = $signed(cal_a[47:32]); ac2 = $signed(cal_a[31:16]); ac3 = $signed(cal_a[15:0]);
        ac4 = {16'd0, cal_b[47:32]}; ac5 = {16'd0, cal_b[31:16]}; ac6 = {16'd0, cal_b[15:0]};
        b1 = $signed(cal_c[47:32]); b2 = $signed(cal_c[31:16]);
        mc = $signed(cal_d[31:16]); md = $signed(cal_d[15:0]);
        r = '0;
        r.divide_error = 1'b1;
        x1 = ($signed({16'd0, s.raw_temperature}) - ac6) * ac5 >>> 15;
        den = x1 + md;
        if (den == 0)
            return r;
        x2 = sdiv(mc * 2048, den);
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x3 = ((b2 * sq) >>> 11) + ((ac2 * b6) >>> 11);
        b3 = sdiv(((ac1 * 4 + x3) << cal_oss) + 2, 4);
        x3 = sdiv(((ac3 * b6) >>> 13) + ((b1 * sq) >>> 16) + 2, 4);
        b4 = (ac4 * (x3 + 32768)) >> 15;
        if (b4 == 0)
            return r;
        b7 = ({13'd0, s.raw_pressure} - b3) * (32'd50000 >> cal_oss);
        q = b7[31] ? (b7 / b4) * 2 : (b7 * 2) / b4;
        p = q;
        x1 = (((p >>> 8) * (p >>> 8)) * 3038) >>> 16;
        x2 = (-32'sd7357 * p) >>> 16;
        p = p + ((x1 + x2 + 3791) >>> 4);
        r.temperature_decicelsius = t;
        r.pressure_pascal = p;
        r.divide_error = 1'b0;
        return r;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        unique case (idx)
            REG_COEF_A: cal_a = value;
            REG_COEF_B: cal_b = value;
            REG_COEF_C: cal_c = value;
            REG_COEF_D: cal_d = value[31:0];
            REG_OSS:    cal_oss = value[1:0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                    logic [31:0] d, logic [1:0] oss);
        write_reg(REG_COEF_A, a);
        write_reg(REG_COEF_B, b);
        write_reg(REG_COEF_C, c);
        write_reg(REG_COEF_D, {16'd0, d});
        write_reg(REG_OSS, {46'd0, oss});
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(in_beat_t s, bit known, out_beat_t given, bit use_gaps);
        out_beat_t r;
        int gap;
        gap = use_gaps ? $urandom_range(0, 7) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r = compensate(s);
        if (known && r !== given)
        begin
            $error("table row disagrees with predictor: table %h predictor %h", given, r);
            errors++;
        end
        pending_results.push_back(r);
        in_valid <= 1'b1;
        in_data  <= s;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    function automatic in_beat_t rand_sample();
        in_beat_t s;
        s.raw_temperature = 16'($urandom_range(0, 65535));
        s.raw_pressure = 19'($urandom_range(0, 524287));
        return s;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            rx_wait = $urandom_range(0, 7);
        else if (rx_wait != 0)
            rx_wait--;
        out_stall <= hold_off || (rx_wait != 0);
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", out_data);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                beats_out++;
                if (want.divide_error)
                    error_beats++;
                if (out_data.temperature_decicelsius !== want.temperature_decicelsius)
                begin
                    $error("temperature_decicelsius expected %0d actual %0d",
                           want.temperature_decicelsius, out_data.temperature_decicelsius);
                    errors++;
                end
                if (out_data.pressure_pascal !== want.pressure_pascal)
                begin
                    $error("pressure_pascal expected %0d actual %0d",
                           want.pressure_pascal, out_data.pressure_pascal);
                    errors++;
                end
                if (out_data.divide_error !== want.divide_error)
                begin
                    $error("divide_error expected %0d actual %0d",
                           want.divide_error, out_data.divide_error);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [47:0] std_a, std_b, std_c;
        logic [31:0] std_d;
        out_beat_t   err_beat;
        vector_t     v;
        cal_a = '0; cal_b = '0; cal_c = '0; cal_d = '0; cal_oss = 2'd3;
        err_beat = '0;
        err_beat.divide_error = 1'b1;
        std_a = {16'd408, -16'sd72, -16'sd14383};
        std_b = {16'd32741, 16'd32757, 16'd23153};
        std_c = {16'd6190, 16'd4, -16'sd32768};
        std_d = {-16'sd8711, 16'd2868};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all-zero calibration after reset: X1+MD is zero
        vectors.push_back('{'{16'd0, 19'd0}, 1'b1, err_beat});
        vectors.push_back('{'{16'hFFFF, 19'h7FFFF}, 1'b1, err_beat});
        foreach (vectors[i])
            send_sample(vectors[i].sample, vectors[i].known, vectors[i].result, 1'b0);
        drain();

        load_calibration(std_a, std_b, std_c, std_d, 2'd0);
        vectors.delete();
        vectors.push_back('{'{16'd27898, 19'd23843}, 1'b0, '0});
        vectors.push_back('{'{16'd0, 19'd0}, 1'b0, '0});
        vectors.push_back('{'{16'hFFFF, 19'h7FFFF}, 1'b0, '0});
        vectors.push_back('{'{16'd23153, 19'h40000}, 1'b0, '0});
        vectors.push_back('{'{16'h8000, 19'd1}, 1'b0, '0});
        foreach (vectors[i])
            send_sample(vectors[i].sample, vectors[i].known, vectors[i].result, 1'b1);
        drain();

        // AC4 of zero makes B4 zero
        load_calibration(std_a, {16'd0, std_b[31:0]}, std_c, std_d, 2'd3);
        send_sample('{16'd27898, 19'd23843}, 1'b1, err_beat, 1'b0);
        send_sample('{16'hFFFF, 19'h7FFFF}, 1'b1, err_beat, 1'b0);
        drain();

        // extreme coefficients, full-scale and minimum words
        load_calibration(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h8000_7FFF_8000,
                         32'h7FFF_8000, 2'd3);
        send_sample('{16'd0, 19'd0}, 1'b0, '0, 1'b0);
        send_sample('{16'hFFFF, 19'h7FFFF}, 1'b0, '0, 1'b0);
        send_sample('{16'h5555, 19'h2AAAA}, 1'b0, '0, 1'b0);
        drain();

        // long receiver hold-off while input keeps coming
        load_calibration(std_a, std_b, std_c, std_d, 2'd1);
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (150) send_sample(rand_sample(), 1'b0, '0, 1'b0);
        join
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase < 4)
                load_calibration(std_a ^ (rand48() & 48'h00FF_00FF_00FF), std_b, std_c,
                                 std_d, phase[1:0]);
            else
                load_calibration(rand48(), rand48(), rand48(), $urandom(),
                                 2'($urandom_range(0, 3)));
            repeat (95)
                send_sample(rand_sample(), 1'b0, '0, ($urandom_range(0, 4) != 0));
            drain();
        end

        $display("Covered %0d result beats (%0d divide errors) over directed, hold-off and",
                 beats_out, error_beats);
        $display("random calibration sets at every oversampling setting.");
        if (errors == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
